/* rtl/dllp_pkg.sv */
// ----------------------------------------------------------------------------
// dllp_pkg
// Shared types and constants for the linked-list node pool: request and
// response beats, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package dllp_pkg;

  // Pool size; the value NODES itself is the null handle
  localparam int NODES  = 256;

  // Field widths of the request and response beats
  localparam int PTR_W  = $clog2(NODES) + 1;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_INS_AFTER  = 2'd0,
    REQ_INS_BEFORE = 2'd1,
    REQ_REMOVE     = 2'd2,
    REQ_READ       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WB
  } state_t;

  typedef struct packed {
    req_t               req_type;
    logic [PTR_W-1:0]   handle;
    logic [DATA_W-1:0]  data_in;
  } req_beat_t;

  typedef struct packed {
    status_t            status;
    logic [PTR_W-1:0]   node_out;
    logic [DATA_W-1:0]  data_out;
    logic [PTR_W-1:0]   next_out;
    logic [PTR_W-1:0]   prev_out;
    logic [PTR_W-1:0]   head_out;
    logic [PTR_W-1:0]   tail_out;
    logic [PTR_W-1:0]   count_out;
  } rsp_beat_t;

  // One write to a link memory
  typedef struct packed {
    logic               en;
    logic [PTR_W-1:0]   addr;
    logic [PTR_W-1:0]   val;
  } link_wr_t;

endpackage

/* rtl/dllp_ram.sv */
// ----------------------------------------------------------------------------
// dllp_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module dllp_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/doubly_linked_list_pool.sv */
// A request is read when accepted, does its first write-back in EXEC and its second
// in WB, where its response beat goes out; no new request is taken until IDLE, as set
// by the single write port of each link memory, and rsp_stall holds WB longer.
// Reset clears head, tail, count, free list and fresh counter; the node memories
// are not cleared and are defined only once written.
// ----------------------------------------------------------------------------
// doubly_linked_list_pool
// Doubly linked list in a fixed pool of nodes with a free list and a fresh-node
// counter. Links and data live in synchronous RAMs; each request reads its node
// then writes back in up to two passes.
// ----------------------------------------------------------------------------
module doubly_linked_list_pool (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dllp_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dllp_pkg::rsp_beat_t rsp
);

  import dllp_pkg::*;

  localparam int              IW    = $clog2(NODES);
  localparam logic [PTR_W-1:0] NIL   = PTR_W'(NODES);
  localparam logic [PTR_W-1:0] OMASK = PTR_W'(2 * NODES - 1);

  state_t             state;
  state_t             state_next;

  // Request held for the duration of its work
  req_t               cur_req;
  logic [PTR_W-1:0]   cur_h;
  logic [DATA_W-1:0]  cur_din;

  // List registers
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [PTR_W-1:0]   cnt, cnt_next;
  logic [PTR_W-1:0]   free_head, free_head_next;
  logic [PTR_W-1:0]   fresh, fresh_next;

  // Memory read data
  logic [PTR_W-1:0]   rd_next;
  logic [PTR_W-1:0]   rd_fnext;
  logic [PTR_W-1:0]   rd_prev;
  logic [DATA_W-1:0]  rd_data;

  // Write-back commands
  link_wr_t           w1n, w1p, w2n, w2p;
  link_wr_t           w2n_q, w2p_q;
  logic               w1d_en;
  logic [PTR_W-1:0]   nn;

  rsp_beat_t          res, res_next;

  logic               accept;
  logic               wb_go;
  logic [PTR_W-1:0]   h_in;

  logic               next_we;
  logic [PTR_W-1:0]   next_waddr, next_wdata;
  logic               prev_we;
  logic [PTR_W-1:0]   prev_waddr, prev_wdata;

  function automatic logic live(input logic [PTR_W-1:0] p);
    return p < NIL;
  endfunction

  // Handshake
  assign accept    = (state == S_IDLE) && req_valid;
  assign req_stall = (state != S_IDLE);
  assign wb_go     = (state == S_WB) && (!rsp_valid || !rsp_stall);
  assign h_in      = (req.handle < NIL) ? req.handle : NIL;

  // Memory write port selection: first pass in EXEC, second pass in WB
  always_comb begin
    if (state == S_EXEC) begin
      next_we    = w1n.en;
      next_waddr = w1n.addr;
      next_wdata = w1n.val;
      prev_we    = w1p.en;
      prev_waddr = w1p.addr;
      prev_wdata = w1p.val;
    end else begin
      next_we    = wb_go && w2n_q.en;
      next_waddr = w2n_q.addr;
      next_wdata = w2n_q.val;
      prev_we    = wb_go && w2p_q.en;
      prev_waddr = w2p_q.addr;
      prev_wdata = w2p_q.val;
    end
  end

  // Next links: one copy read at the handle, one at the free-list head
  dllp_ram #(.WIDTH(PTR_W), .DEPTH(NODES), .AW(IW)) u_next_h (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr[IW-1:0]),
    .wdata (next_wdata),
    .re    (accept),
    .raddr (req.handle[IW-1:0]),
    .rdata (rd_next)
  );

  dllp_ram #(.WIDTH(PTR_W), .DEPTH(NODES), .AW(IW)) u_next_f (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr[IW-1:0]),
    .wdata (next_wdata),
    .re    (accept),
    .raddr (free_head[IW-1:0]),
    .rdata (rd_fnext)
  );

  dllp_ram #(.WIDTH(PTR_W), .DEPTH(NODES), .AW(IW)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr[IW-1:0]),
    .wdata (prev_wdata),
    .re    (accept),
    .raddr (req.handle[IW-1:0]),
    .rdata (rd_prev)
  );

  dllp_ram #(.WIDTH(DATA_W), .DEPTH(NODES), .AW(IW)) u_data (
    .clk   (clk),
    .we    (w1d_en),
    .waddr (nn[IW-1:0]),
    .wdata (cur_din),
    .re    (accept),
    .raddr (req.handle[IW-1:0]),
    .rdata (rd_data)
  );

  // Request decode and list update, evaluated in EXEC on the read data
  always_comb begin
    status_t           st;
    logic [PTR_W-1:0]  node, nx, pv;
    logic [DATA_W-1:0] dout;

    st             = ST_OK;
    node           = cur_h;
    nx             = '0;
    pv             = '0;
    dout           = '0;
    head_next      = head;
    tail_next      = tail;
    cnt_next       = cnt;
    free_head_next = free_head;
    fresh_next     = fresh;
    w1n            = '0;
    w1p            = '0;
    w2n            = '0;
    w2p            = '0;
    w1d_en         = 1'b0;
    nn             = live(free_head) ? free_head : fresh;

    case (cur_req)
      REQ_INS_AFTER, REQ_INS_BEFORE: begin
        if (cur_h == NIL && cnt != '0) begin
          st = ST_NULL;
        end else if (!live(free_head) && fresh >= NIL) begin
          st = ST_FULL;
        end else begin
          // take a node from the free list, else a fresh one
          if (live(free_head)) begin
            free_head_next = rd_fnext;
          end else begin
            fresh_next = fresh + PTR_W'(1);
          end
          w1d_en = 1'b1;
          w1n    = '{en: 1'b1, addr: nn, val: NIL};
          w1p    = '{en: 1'b1, addr: nn, val: NIL};
          if (cnt == '0) begin
            head_next = nn;
            tail_next = nn;
          end else if (cur_req == REQ_INS_AFTER) begin
            w1n.val = rd_next;
            w1p.val = cur_h;
            if (!live(rd_next)) begin
              tail_next = nn;
            end else begin
              w2p = '{en: 1'b1, addr: rd_next, val: nn};
            end
            w2n = '{en: 1'b1, addr: cur_h, val: nn};
          end else begin
            w1n.val = cur_h;
            w1p.val = rd_prev;
            if (!live(rd_prev)) begin
              head_next = nn;
            end else begin
              w2n = '{en: 1'b1, addr: rd_prev, val: nn};
            end
            w2p = '{en: 1'b1, addr: cur_h, val: nn};
          end
          if (cnt < NIL) begin
            cnt_next = cnt + PTR_W'(1);
          end
          node = nn;
          dout = cur_din;
          // links of the new node after both passes
          nx   = (w2n.en && w2n.addr == nn) ? nn : w1n.val;
          pv   = (w2p.en && w2p.addr == nn) ? nn : w1p.val;
        end
      end
      REQ_REMOVE: begin
        if (cnt == '0) begin
          st = ST_EMPTY;
        end else if (cur_h == NIL) begin
          st = ST_NULL;
        end else begin
          dout = rd_data;
          nx   = rd_next;
          pv   = rd_prev;
          if (cur_h == head) begin
            head_next = rd_next;
            if (!live(rd_next)) begin
              tail_next = NIL;
            end else begin
              w1p = '{en: 1'b1, addr: rd_next, val: NIL};
            end
          end else begin
            if (live(rd_prev)) begin
              w1n = '{en: 1'b1, addr: rd_prev, val: rd_next};
            end
            if (!live(rd_next)) begin
              tail_next = rd_prev;
            end else begin
              w1p = '{en: 1'b1, addr: rd_next, val: rd_prev};
            end
          end
          // push the removed node onto the free list
          w2n            = '{en: 1'b1, addr: cur_h, val: free_head};
          free_head_next = cur_h;
          cnt_next       = cnt - PTR_W'(1);
        end
      end
      REQ_READ: begin
        if (cur_h == NIL) begin
          st = ST_NULL;
        end else begin
          dout = rd_data;
          nx   = rd_next;
          pv   = rd_prev;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase

    // first-pass writes only happen in EXEC
    if (state != S_EXEC) begin
      w1n.en = 1'b0;
      w1p.en = 1'b0;
      w1d_en = 1'b0;
    end

    res_next.status    = st;
    res_next.node_out  = node & OMASK;
    res_next.data_out  = dout;
    res_next.next_out  = nx & OMASK;
    res_next.prev_out  = pv & OMASK;
    res_next.head_out  = head_next & OMASK;
    res_next.tail_out  = tail_next & OMASK;
    res_next.count_out = cnt_next & OMASK;
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_WB;
      end
      S_WB: begin
        if (wb_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cnt       <= '0;
      free_head <= NIL;
      fresh     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        head      <= head_next;
        tail      <= tail_next;
        cnt       <= cnt_next;
        free_head <= free_head_next;
        fresh     <= fresh_next;
      end
      if (wb_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_req <= req.req_type;
      cur_h   <= h_in;
      cur_din <= req.data_in;
    end
    if (state == S_EXEC) begin
      res   <= res_next;
      w2n_q <= w2n;
      w2p_q <= w2p;
    end
    if (wb_go) begin
      rsp <= res;
    end
  end

endmodule

/* dv/tb_doubly_linked_list_pool.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_pool
// Self-checking bench for the pooled doubly linked list. Request beats are
// queued with their expected response beats, which a behavioural copy of the
// pool works out. A clocked driver and a clocked monitor move beats under
// random idling and back-pressure, and the monitor checks every response
// field by field.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_pool;
  import dllp_pkg::*;

  localparam int                IW    = $clog2(NODES);
  localparam logic [PTR_W-1:0]  NIL   = 9'd256;
  localparam int                RAND_PER_PHASE = 320;

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_beat_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_beat_t rsp;

  doubly_linked_list_pool dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Beats waiting to go out and responses still owed by the block
  req_beat_t pending_reqs[$];
  rsp_beat_t owed_rsps[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int rsp_seen      = 0;

  // Behavioural copy of the pool
  logic [PTR_W-1:0]  next_mem [NODES];
  logic [PTR_W-1:0]  prev_mem [NODES];
  logic [DATA_W-1:0] data_mem [NODES];
  logic [PTR_W-1:0]  head_q, tail_q, size_q, free_q, fresh_q;

  // Stimulus bookkeeping: nodes believed to be on the list
  bit  on_list [NODES];
  bit  growing     = 1'b1;
  int  grow_target = NODES;
  bit  seen_full   = 1'b0;
  int  status_tally [4];
  int  op_tally [4];
  int  peak_size   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("tb_doubly_linked_list_pool NOT OK");
    $finish;
  end

  function automatic void clear_pool();
    for (int i = 0; i < NODES; i++) begin
      next_mem[i] = '0;
      prev_mem[i] = '0;
      data_mem[i] = '0;
      on_list[i]  = 1'b0;
    end
    head_q  = NIL;
    tail_q  = NIL;
    size_q  = '0;
    free_q  = NIL;
    fresh_q = '0;
  endfunction

  // Applies one request to the pool copy and returns the response it owes
  function automatic rsp_beat_t apply_request(req_beat_t r);
    rsp_beat_t        o;
    logic [PTR_W-1:0] h, nn, nb, n, p;
    o = '0;
    h = (r.handle < NIL) ? r.handle : NIL;
    o.status   = ST_OK;
    o.node_out = h;
    case (r.req_type)
      REQ_INS_AFTER, REQ_INS_BEFORE: begin
        if (h == NIL && size_q != 0) begin
          o.status = ST_NULL;
        end else if (!(free_q < NIL) && fresh_q >= NIL) begin
          o.status = ST_FULL;
        end else begin
          // free list first, then a fresh node
          if (free_q < NIL) begin
            nn     = free_q;
            free_q = next_mem[nn[IW-1:0]];
          end else begin
            nn      = fresh_q;
            fresh_q = fresh_q + 1'b1;
          end
          data_mem[nn[IW-1:0]] = r.data_in;
          if (size_q == 0) begin
            next_mem[nn[IW-1:0]] = NIL;
            prev_mem[nn[IW-1:0]] = NIL;
            head_q       = nn;
            tail_q       = nn;
          end else if (r.req_type == REQ_INS_AFTER) begin
            nb           = next_mem[h[IW-1:0]];
            next_mem[nn[IW-1:0]] = nb;
            prev_mem[nn[IW-1:0]] = h;
            if (nb >= NIL) tail_q = nn;
            else prev_mem[nb[IW-1:0]] = nn;
            next_mem[h[IW-1:0]] = nn;
          end else begin
            nb           = prev_mem[h[IW-1:0]];
            next_mem[nn[IW-1:0]] = h;
            prev_mem[nn[IW-1:0]] = nb;
            if (nb >= NIL) head_q = nn;
            else next_mem[nb[IW-1:0]] = nn;
            prev_mem[h[IW-1:0]] = nn;
          end
          if (size_q < NIL) size_q = size_q + 1'b1;
          o.node_out = nn;
          o.data_out = r.data_in;
          o.next_out = next_mem[nn[IW-1:0]];
          o.prev_out = prev_mem[nn[IW-1:0]];
        end
      end
      REQ_REMOVE: begin
        if (size_q == 0) begin
          o.status = ST_EMPTY;
        end else if (h == NIL) begin
          o.status = ST_NULL;
        end else begin
          n = next_mem[h[IW-1:0]];
          p = prev_mem[h[IW-1:0]];
          o.data_out = data_mem[h[IW-1:0]];
          o.next_out = n;
          o.prev_out = p;
          if (h == head_q) begin
            head_q = n;
            if (n >= NIL) tail_q = NIL;
            else prev_mem[n[IW-1:0]] = NIL;
          end else begin
            if (p < NIL) next_mem[p[IW-1:0]] = n;
            if (n >= NIL) tail_q = p;
            else prev_mem[n[IW-1:0]] = p;
          end
          next_mem[h[IW-1:0]] = free_q;
          free_q      = h;
          size_q      = size_q - 1'b1;
        end
      end
      default: begin
        if (h == NIL) begin
          o.status = ST_NULL;
        end else begin
          o.data_out = data_mem[h[IW-1:0]];
          o.next_out = next_mem[h[IW-1:0]];
          o.prev_out = prev_mem[h[IW-1:0]];
        end
      end
    endcase
    o.head_out  = head_q;
    o.tail_out  = tail_q;
    o.count_out = size_q;
    return o;
  endfunction

  // Queues one request beat together with the response it should produce
  task automatic queue_request(req_t op, logic [PTR_W-1:0] hdl, logic [DATA_W-1:0] d);
    req_beat_t r;
    rsp_beat_t e;
    r.req_type = op;
    r.handle   = hdl;
    r.data_in  = d;
    e = apply_request(r);
    if (e.status == ST_OK) begin
      if (op == REQ_INS_AFTER || op == REQ_INS_BEFORE) on_list[e.node_out[IW-1:0]] = 1'b1;
      else if (op == REQ_REMOVE) on_list[hdl[IW-1:0]] = 1'b0;
    end
    if (e.status == ST_FULL) seen_full = 1'b1;
    status_tally[e.status]++;
    op_tally[op]++;
    if (int'(size_q) > peak_size) peak_size = int'(size_q);
    pending_reqs.push_back(r);
    owed_rsps.push_back(e);
  endtask

  function automatic logic [PTR_W-1:0] pick_live();
    int cand[$];
    for (int i = 0; i < NODES; i++) if (on_list[i]) cand.push_back(i);
    if (cand.size() == 0) return NIL;
    return PTR_W'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  // Written once but not on the list now
  function automatic logic [PTR_W-1:0] pick_stale();
    int cand[$];
    for (int i = 0; i < NODES; i++) if (i < fresh_q && !on_list[i]) cand.push_back(i);
    if (cand.size() == 0) return NIL;
    return PTR_W'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  // One random request; the mix leans towards growing or draining the list
  task automatic random_request();
    int               roll, hm;
    req_t             op;
    logic [PTR_W-1:0] hdl;
    logic [DATA_W-1:0] d;
    roll = $urandom_range(0, 99);
    if (growing)
      op = (roll < 40) ? REQ_INS_AFTER : (roll < 80) ? REQ_INS_BEFORE :
           (roll < 85) ? REQ_REMOVE : REQ_READ;
    else
      op = (roll < 10) ? REQ_INS_AFTER : (roll < 20) ? REQ_INS_BEFORE :
           (roll < 85) ? REQ_REMOVE : REQ_READ;
    hm = $urandom_range(0, 99);
    if (hm < 4)                    hdl = NIL;
    else if (hm < 7)               hdl = PTR_W'($urandom_range(257, 511));
    else if (hm < 9 && seen_full)  hdl = pick_stale();
    else                           hdl = pick_live();
    // an empty list ignores the handle of an insert and refuses any remove
    if (size_q == 0 && op != REQ_READ && $urandom_range(0, 1) == 1)
      hdl = PTR_W'($urandom_range(0, 511));
    d = $urandom();
    case ($urandom_range(0, 15))
      0:       d = '0;
      1:       d = '1;
      default: ;
    endcase
    queue_request(op, hdl, d);
    if (growing && size_q >= grow_target && $urandom_range(0, 3) == 0) begin
      growing = 1'b0;
    end else if (!growing && size_q == 0 && $urandom_range(0, 3) == 0) begin
      growing     = 1'b1;
      grow_target = ($urandom_range(0, 3) == 0) ? NODES : $urandom_range(1, 40);
    end
  endtask

  task automatic check_field(string label, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: response %0d %s: expected 0x%0h, got 0x%0h",
               $time, rsp_seen, label, want, got);
    end
  endtask

  task automatic check_response(rsp_beat_t want, rsp_beat_t got);
    check_field("status", DATA_W'(want.status), DATA_W'(got.status));
    check_field("node_out", DATA_W'(want.node_out), DATA_W'(got.node_out));
    check_field("data_out", want.data_out, got.data_out);
    check_field("next_out", DATA_W'(want.next_out), DATA_W'(got.next_out));
    check_field("prev_out", DATA_W'(want.prev_out), DATA_W'(got.prev_out));
    check_field("head_out", DATA_W'(want.head_out), DATA_W'(got.head_out));
    check_field("tail_out", DATA_W'(want.tail_out), DATA_W'(got.tail_out));
    check_field("count_out", DATA_W'(want.count_out), DATA_W'(got.count_out));
  endtask

  // Request driver: a new beat only once the current one has gone
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsps.size() == 0) begin
          mismatches++;
          $display("%0t: response beat with nothing expected: expected none, got 0x%0h",
                   $time, rsp);
        end else begin
          check_response(owed_rsps.pop_front(), rsp);
        end
        rsp_seen++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int send_mix [4];
    int stall_mix [4];
    send_mix  = '{0, 78, 0, 34};
    stall_mix = '{0, 0, 78, 34};
    clear_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-list corners, then a null handle on a one-node list
    queue_request(REQ_READ, NIL, 32'h0);
    queue_request(REQ_REMOVE, 9'd0, 32'h0);
    queue_request(REQ_REMOVE, NIL, 32'h0);
    queue_request(REQ_INS_AFTER, 9'd511, 32'hFFFF_FFFF);
    queue_request(REQ_INS_BEFORE, NIL, 32'h1);
    // build 2 0 4 1 3: new head, new tail, middle
    queue_request(REQ_INS_AFTER, 9'd0, 32'h0);
    queue_request(REQ_INS_BEFORE, 9'd0, 32'hA5A5_A5A5);
    queue_request(REQ_INS_AFTER, 9'd1, 32'h5A5A_5A5A);
    queue_request(REQ_INS_BEFORE, 9'd1, 32'h1234_5678);
    queue_request(REQ_READ, 9'd0, 32'h0);
    queue_request(REQ_READ, 9'd4, 32'h0);
    queue_request(REQ_READ, 9'd3, 32'h0);
    // null and out-of-range handles on a live list
    queue_request(REQ_REMOVE, NIL, 32'h0);
    queue_request(REQ_REMOVE, 9'd300, 32'h0);
    // remove head, tail and a middle node, then reuse from the free list
    queue_request(REQ_REMOVE, 9'd2, 32'h0);
    queue_request(REQ_REMOVE, 9'd3, 32'h0);
    queue_request(REQ_REMOVE, 9'd4, 32'h0);
    queue_request(REQ_INS_BEFORE, 9'd1, 32'hDEAD_BEEF);
    queue_request(REQ_INS_AFTER, 9'd0, 32'h8000_0001);
    queue_request(REQ_READ, 9'd257, 32'h0);
    queue_request(REQ_READ, 9'd1, 32'h0);
    queue_request(REQ_INS_AFTER, 9'd1, 32'h7FFF_FFFF);

    // random phases, each with its own idling mix
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      send_idle_pct = send_mix[ph];
      stall_pct     = stall_mix[ph];
      for (int i = 0; i < RAND_PER_PHASE; i++) random_request();
      while (pending_reqs.size() != 0 || owed_rsps.size() != 0) @(negedge clk);
    end
    repeat (12) @(negedge clk);

    $display("Covered %0d requests (after %0d, before %0d, remove %0d, read %0d), peak size %0d",
             rsp_seen, op_tally[REQ_INS_AFTER], op_tally[REQ_INS_BEFORE],
             op_tally[REQ_REMOVE], op_tally[REQ_READ], peak_size);
    $display("Status seen: ok %0d, null handle %0d, pool exhausted %0d, list empty %0d",
             status_tally[ST_OK], status_tally[ST_NULL], status_tally[ST_FULL],
             status_tally[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("tb_doubly_linked_list_pool OK");
    end else begin
      $display("tb_doubly_linked_list_pool NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dllp_pkg.sv
rtl/dllp_ram.sv
rtl/doubly_linked_list_pool.sv
dv/tb_doubly_linked_list_pool.sv
